// File: rtl/core/assert_macros.svh
// Assertion macros shared by the date subtractor RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CDMD_ASSERT_ON(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cdmd assertion failed");

// Check that a condition never holds outside reset.
`define CDMD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `CDMD_ASSERT_ON(lbl, clk, rstn, !(cond))

`endif

// File: rtl/core/cdmd_pkg.sv
// Shared types, constants and calendar functions of the date subtractor.
// Depends on nothing; used by the controller, datapath, top level, checker and testbench.
package cdmd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DaysW  = 12;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [DayW-1:0] DayFirst   = 5'd1;
  localparam logic [DayW-1:0] DayDecLast = 5'd31;
  localparam logic [DayW-1:0] DayFebLeap = 5'd29;

  // Multiplicative inverse of 25 modulo 2**14 and the divisibility bound
  localparam logic [YearW-1:0] Inv25    = 14'd7209;
  localparam logic [YearW-1:0] Div25Lim = 14'd655;

  // Month lengths of a common year, January first
  localparam logic [DayW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [DaysW-1:0]  days_back;
  } in_word_t;

  typedef struct packed {
    logic [YearW-1:0]  end_year;
    logic [MonthW-1:0] end_month;
    logic [DayW-1:0]   end_day;
    logic              underflow;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic norm;
    logic step;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

  // Gregorian leap rule: divisible by 100 tested as divisible by 4 and by 25,
  // divisible by 400 then reduces to divisible by 16.
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [2*YearW-1:0] prod;
    logic               div4;
    logic               div25;
    logic               div16;
    prod  = year * Inv25;
    div4  = (year[1:0] == 2'd0);
    div16 = (year[3:0] == 4'd0);
    div25 = (prod[YearW-1:0] <= Div25Lim);
    return div4 && (!div25 || div16);
  endfunction

  // Length of a month, month in 1..12
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] month,
                                              input logic leap);
    logic [MonthW-1:0] idx;
    idx = month - MonthJan;
    if (month == MonthFeb && leap) begin
      return DayFebLeap;
    end
    return MonthLen[idx];
  endfunction

endpackage

// File: rtl/core/cdmd_stream_if.sv
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; payload types come from cdmd_pkg at the instance.
interface cdmd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/core/cdmd_ctrl.sv
// Sequencing state machine of the date subtractor.
// Depends on cdmd_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"

module cdmd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cdmd_pkg::sts_t sts_i,
  output cdmd_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StNorm = 4'b0010,
    StStep = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q;
  state_e state_d;

  // Take a new word only when no item is in flight
  assign req_ready_o = (state_q == StIdle);

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StNorm;
        end
      end
      StNorm: begin
        cmd_o.norm = 1'b1;
        state_d    = StStep;
      end
      StStep: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `CDMD_ASSERT_ON(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `CDMD_ASSERT_ON(a_load_to_norm, clk_i, rst_ni, cmd_o.load |=> state_q == StNorm)
  `CDMD_ASSERT_NEVER(a_emit_blocked, clk_i, rst_ni, cmd_o.emit && !sts_i.out_free)

endmodule

// File: rtl/core/cdmd_dpath.sv
// Date registers, month stepping logic and result register.
// Depends on cdmd_pkg and assert_macros.svh; commanded by cdmd_ctrl.
`include "assert_macros.svh"

module cdmd_dpath #(
  parameter int unsigned MAX_DAYS_BACK = 4095
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdmd_pkg::cmd_t      cmd_i,
  output cdmd_pkg::sts_t      sts_o,
  input  cdmd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cdmd_pkg::out_word_t out_word_o
);

  localparam int unsigned YearW  = cdmd_pkg::YearW;
  localparam int unsigned MonthW = cdmd_pkg::MonthW;
  localparam int unsigned DayW   = cdmd_pkg::DayW;
  localparam int unsigned DaysW  = cdmd_pkg::DaysW;

  // Saturation value of the day count
  localparam logic [DaysW-1:0] SatCount =
    (MAX_DAYS_BACK >= (1 << DaysW) - 1) ? {DaysW{1'b1}} : DaysW'(MAX_DAYS_BACK);

  logic [YearW-1:0]  year_q,  year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q,   day_d;
  logic [DaysW-1:0]  count_q, count_d;
  logic              uf_q,    uf_d;
  logic              leap_q,  leap_d;
  logic              out_valid_q, out_valid_d;
  cdmd_pkg::out_word_t out_word_q;

  logic [MonthW-1:0] month_in;
  logic [DaysW-1:0]  count_in;
  logic [DayW-1:0]   cur_len;
  logic [DayW-1:0]   prev_len;
  logic [YearW-1:0]  leap_year;

  // Clamp the incoming month and count
  always_comb begin
    month_in = in_word_i.start_month;
    if (in_word_i.start_month < cdmd_pkg::MonthJan) begin
      month_in = cdmd_pkg::MonthJan;
    end else if (in_word_i.start_month > cdmd_pkg::MonthDec) begin
      month_in = cdmd_pkg::MonthDec;
    end
    count_in = (in_word_i.days_back > SatCount) ? SatCount : in_word_i.days_back;
  end

  // Track the leap flag of the held year; load it straight from the input word
  assign leap_year = cmd_i.load ? in_word_i.start_year : year_q;
  assign leap_d    = cdmd_pkg::is_leap(leap_year);

  // Month lengths of the held month and the month before it
  assign cur_len  = cdmd_pkg::days_in(month_q, leap_q);
  assign prev_len = cdmd_pkg::days_in(month_q - cdmd_pkg::MonthJan, leap_q);

  // Load, normalize the day, or step back within the month or by one month
  always_comb begin
    year_d     = year_q;
    month_d    = month_q;
    day_d      = day_q;
    count_d    = count_q;
    uf_d       = uf_q;
    sts_o.last = 1'b0;
    if (cmd_i.load) begin
      year_d  = in_word_i.start_year;
      month_d = month_in;
      day_d   = in_word_i.start_day;
      count_d = count_in;
      uf_d    = 1'b0;
    end else if (cmd_i.norm) begin
      if (day_q < cdmd_pkg::DayFirst) begin
        day_d = cdmd_pkg::DayFirst;
      end else if (day_q > cur_len) begin
        day_d = cur_len;
      end
    end else if (cmd_i.step) begin
      if (count_q == '0) begin
        sts_o.last = 1'b1;
      end else if (count_q < DaysW'(day_q)) begin
        day_d      = day_q - count_q[DayW-1:0];
        count_d    = '0;
        sts_o.last = 1'b1;
      end else begin
        count_d = count_q - DaysW'(day_q);
        if (month_q > cdmd_pkg::MonthJan) begin
          month_d = month_q - cdmd_pkg::MonthJan;
          day_d   = prev_len;
        end else if (year_q != '0) begin
          year_d  = year_q - YearW'(1);
          month_d = cdmd_pkg::MonthDec;
          day_d   = cdmd_pkg::DayDecLast;
        end else begin
          year_d     = '0;
          month_d    = cdmd_pkg::MonthJan;
          day_d      = cdmd_pkg::DayFirst;
          uf_d       = 1'b1;
          sts_o.last = 1'b1;
        end
      end
    end
  end

  // Hold the result until the sink takes it
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_d    = cmd_i.emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    count_q <= count_d;
    uf_q    <= uf_d;
    leap_q  <= leap_d;
    if (cmd_i.emit) begin
      out_word_q.end_year  <= year_q;
      out_word_q.end_month <= month_q;
      out_word_q.end_day   <= day_q;
      out_word_q.underflow <= uf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `CDMD_ASSERT_NEVER(a_step_day_zero, clk_i, rst_ni, cmd_i.step && day_q == '0)
  `CDMD_ASSERT_ON(a_step_month_range, clk_i, rst_ni,
    cmd_i.step |-> (month_q >= cdmd_pkg::MonthJan && month_q <= cdmd_pkg::MonthDec))
  `CDMD_ASSERT_ON(a_underflow_floor, clk_i, rst_ni,
    (out_valid_q && out_word_q.underflow) |->
      (out_word_q.end_year == '0 && out_word_q.end_month == cdmd_pkg::MonthJan &&
       out_word_q.end_day == cdmd_pkg::DayFirst))

endmodule

// File: rtl/core/calendar_date_minus_days_core.sv
// Top level of the Gregorian date subtractor: controller plus datapath.
// Depends on cdmd_pkg, cdmd_stream_if, cdmd_ctrl and cdmd_dpath.
//
//   channel  direction  payload                                          role
//   req_i    in         start_year, start_month, start_day, days_back    date query
//   rsp_o    out        end_year, end_month, end_day, underflow          earlier date
//
// Each item is loaded, has its day normalized, then steps back one month boundary
// at a time in the month stepping loop until the count is used up.
// req_i is ready only while no item is in flight; the result sits in an output
// register, so a stalled rsp_o does not block the next query's computation.
// Reset clears the state machine and the output valid flag only.
module calendar_date_minus_days_core #(
  parameter int unsigned MAX_DAYS_BACK = 4095
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cdmd_stream_if.sink         req_i,
  cdmd_stream_if.source       rsp_o
);

  cdmd_pkg::cmd_t cmd;
  cdmd_pkg::sts_t sts;
  cdmd_pkg::in_word_t  in_word;
  cdmd_pkg::out_word_t out_word;
  logic                req_ready;
  logic                out_valid;

  assign in_word = req_i.payload;

  cdmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdmd_dpath #(
    .MAX_DAYS_BACK (MAX_DAYS_BACK)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .out_word_o  (out_word)
  );

  // Drive the channel ports
  assign req_i.ready   = req_ready;
  assign rsp_o.valid   = out_valid;
  assign rsp_o.payload = out_word;

endmodule

// File: dv/cdmd_date_checker.sv
// Checker for the date subtractor: watches the query and result channels,
// predicts each earlier date and compares it with the result word.
// Depends on cdmd_pkg for the word types.
module cdmd_date_checker #(
  parameter int unsigned MAX_DAYS_BACK = 4095
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  cdmd_pkg::in_word_t  req_word_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  cdmd_pkg::out_word_t rsp_word_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cdmd_pkg::out_word_t expected_dates[$];
  int unsigned         mismatches = 0;

  function automatic bit leap_year(input int unsigned year);
    return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned year,
                                             input int unsigned month);
    if (month == cdmd_pkg::MonthFeb) begin
      return leap_year(year) ? 29 : 28;
    end
    case (month)
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Walk back one month at a time until the count is used up
  function automatic cdmd_pkg::out_word_t earlier_date(input cdmd_pkg::in_word_t query);
    int unsigned         year;
    int unsigned         month;
    int unsigned         day;
    int unsigned         left;
    int unsigned         last_day;
    logic                held;
    cdmd_pkg::out_word_t res;
    year  = query.start_year;
    month = query.start_month;
    day   = query.start_day;
    left  = query.days_back;
    held  = 1'b0;
    // Clamp month and day into the calendar, count into its limit
    if (month < cdmd_pkg::MonthJan) month = cdmd_pkg::MonthJan;
    if (month > cdmd_pkg::MonthDec) month = cdmd_pkg::MonthDec;
    last_day = month_days(year, month);
    if (day < 1) day = 1;
    if (day > last_day) day = last_day;
    if (left > MAX_DAYS_BACK) left = MAX_DAYS_BACK;
    while (left > 0) begin
      if (left < day) begin
        day  = day - left;
        left = 0;
      end else begin
        left = left - day;
        if (month > cdmd_pkg::MonthJan) begin
          month = month - 1;
        end else if (year > 0) begin
          year  = year - 1;
          month = cdmd_pkg::MonthDec;
        end else begin
          // Ran past the first day of year zero: hold there and flag it
          day  = 1;
          held = 1'b1;
          break;
        end
        day = month_days(year, month);
      end
    end
    res.end_year  = year[cdmd_pkg::YearW-1:0];
    res.end_month = month[cdmd_pkg::MonthW-1:0];
    res.end_day   = day[cdmd_pkg::DayW-1:0];
    res.underflow = held;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Queue a prediction per accepted query, compare each accepted result word
  always @(posedge clk_i) begin
    cdmd_pkg::out_word_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        expected_dates.push_back(earlier_date(req_word_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_dates.size() == 0) begin
          $error("result word %0d-%0d-%0d with no query pending",
                 rsp_word_i.end_year, rsp_word_i.end_month, rsp_word_i.end_day);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          check_field("end_year", 16'(want.end_year), 16'(rsp_word_i.end_year));
          check_field("end_month", 16'(want.end_month), 16'(rsp_word_i.end_month));
          check_field("end_day", 16'(want.end_day), 16'(rsp_word_i.end_day));
          check_field("underflow", 16'(want.underflow), 16'(rsp_word_i.underflow));
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_dates.size();
  end

endmodule

// File: dv/calendar_date_minus_days_core_test.sv
// Testbench top for the date subtractor: clock, reset, query stimulus,
// result back-pressure, watchdog and verdict. Depends on cdmd_pkg,
// cdmd_stream_if, calendar_date_minus_days_core and cdmd_date_checker.
module calendar_date_minus_days_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomQueries = 550;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 160;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatch_count;
  int unsigned pending_dates;
  int unsigned idle_cycles = 0;

  cdmd_stream_if #(.payload_t(cdmd_pkg::in_word_t))  req_if ();
  cdmd_stream_if #(.payload_t(cdmd_pkg::out_word_t)) rsp_if ();

  calendar_date_minus_days_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cdmd_date_checker date_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_if.valid),
    .req_ready_i      (req_if.ready),
    .req_word_i       (req_if.payload),
    .rsp_valid_i      (rsp_if.valid),
    .rsp_ready_i      (rsp_if.ready),
    .rsp_word_i       (rsp_if.payload),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_dates)
  );

  always #6 clk_i = ~clk_i;

  // Mostly short pauses, now and then a long one
  function automatic int unsigned pause_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cdmd_pkg::in_word_t date_query(input int unsigned year,
                                                    input int unsigned month,
                                                    input int unsigned day,
                                                    input int unsigned count);
    cdmd_pkg::in_word_t w;
    w.start_year  = year[cdmd_pkg::YearW-1:0];
    w.start_month = month[cdmd_pkg::MonthW-1:0];
    w.start_day   = day[cdmd_pkg::DayW-1:0];
    w.days_back   = count[cdmd_pkg::DaysW-1:0];
    return w;
  endfunction

  // Mostly calendar dates, some near year zero, some raw bit patterns
  function automatic cdmd_pkg::in_word_t random_query();
    int unsigned pick;
    int unsigned count;
    pick  = $urandom_range(0, 99);
    count = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
    if (pick < 70) begin
      return date_query($urandom_range(0, 9999), $urandom_range(1, 12),
                        ($urandom_range(0, 1) != 0) ? $urandom_range(1, 28)
                                                    : $urandom_range(1, 31), count);
    end
    if (pick < 85) begin
      return date_query($urandom_range(0, 12), $urandom_range(1, 12),
                        $urandom_range(1, 31), count);
    end
    return date_query($urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  // Hold the word on the channel until the block takes it
  task automatic send_date(input cdmd_pkg::in_word_t w, input int unsigned gap);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Result back-pressure: random stalls between bursts of ready
  initial begin
    int unsigned stall;
    int unsigned burst;
    rsp_if.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = pause_len();
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (burst) @(posedge clk_i);
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned gap;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner dates
    send_date(date_query(2024, 2, 29, 0), pause_len());       // zero count
    send_date(date_query(9999, 12, 31, 4095), pause_len());   // largest nominal date, max count
    send_date(date_query(16383, 15, 31, 4095), pause_len());  // all ones in every field
    send_date(date_query(0, 0, 0, 0), pause_len());           // all zero: month and day clamp
    send_date(date_query(2023, 0, 10, 5), pause_len());       // month zero reads as January
    send_date(date_query(2023, 13, 5, 10), pause_len());      // month above twelve reads as December
    send_date(date_query(2023, 7, 0, 1), pause_len());        // day zero reads as day one
    send_date(date_query(1900, 2, 31, 0), pause_len());       // saturate day, century not leap
    send_date(date_query(2000, 2, 31, 1), pause_len());       // saturate day, 400 rule leap
    send_date(date_query(2023, 4, 31, 30), pause_len());      // saturate to a 30 day month
    send_date(date_query(2023, 3, 15, 15), pause_len());      // count equals day: last of Feb
    send_date(date_query(2001, 1, 1, 1), pause_len());        // cross a year boundary
    send_date(date_query(2100, 3, 1, 1), pause_len());        // century year Feb has 28
    send_date(date_query(2400, 3, 1, 1), pause_len());        // 400 year Feb has 29
    send_date(date_query(0, 3, 1, 1), pause_len());           // year zero is leap
    send_date(date_query(0, 1, 1, 1), pause_len());           // one day before the floor
    send_date(date_query(0, 1, 1, 0), pause_len());           // floor itself, no step
    send_date(date_query(5, 3, 1, 4095), pause_len());        // deep underflow
    send_date(date_query(11, 3, 1, 4060), pause_len());       // lands just above the floor
    send_date(date_query(2024, 3, 1, 366), pause_len());      // whole leap year back
    send_date(date_query(8191, 8, 17, 2730), pause_len());    // alternating bit pattern in the count
    send_date(date_query(12345, 6, 30, 1365), pause_len());   // year beyond nominal range

    // Random queries, with a gap-free stretch every so often
    for (int unsigned i = 0; i < RandomQueries; i++) begin
      gap = ((i / 40) % 5 == 4) ? 0 : pause_len();
      send_date(random_query(), gap);
    end
    req_if.valid <= 1'b0;

    // Let the pending count see the last query, drain, then let the block settle
    @(posedge clk_i);
    while (pending_dates != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: calendar_date_minus_days_core.f
+incdir+rtl/core
rtl/core/cdmd_pkg.sv
rtl/core/cdmd_stream_if.sv
rtl/core/cdmd_ctrl.sv
rtl/core/cdmd_dpath.sv
rtl/core/calendar_date_minus_days_core.sv
dv/cdmd_date_checker.sv
dv/calendar_date_minus_days_core_test.sv
